FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk outside reset.
`define XSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define XSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`endif

FILE: src/xsr_pkg.sv
package xsr_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);

    localparam logic [63:0] SEED_INIT = 64'h05a3_ae52_de3b_bf0a;
    localparam logic [63:0] SEED_MULT = 64'd2685821657736338717;
    localparam logic [63:0] POOL_MULT = 64'd1181783497276652981;

    localparam int SEED_SH1 = 12;
    localparam int SEED_SH2 = 25;
    localparam int SEED_SH3 = 27;
    localparam int POOL_SH1 = 31;
    localparam int POOL_SH2 = 11;
    localparam int POOL_SH3 = 30;

    localparam logic [31:0] RANGE_ZERO = 32'h0000_0000;
    localparam logic [31:0] RANGE_RAW  = 32'hFFFF_FFFF;

    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_RESEED,
        CMD_ONE,
        CMD_RAW,
        CMD_MOD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] range;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: src/xsr_front.sv
module xsr_front import xsr_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // range[31:0]
    input  logic        s_tuser,   // mode[0]
    input  q_status_t   q_status,
    output q_push_t     q_push
);

    always_comb begin
        s_tready          = !q_status.full;
        q_push.valid      = s_tvalid && !q_status.full;
        q_push.cmd.range  = s_tdata;
        if (s_tuser == MODE_RESEED) begin
            q_push.cmd.kind = CMD_RESEED;
        end else if (s_tdata == RANGE_ZERO) begin
            q_push.cmd.kind = CMD_ONE;
        end else if (s_tdata == RANGE_RAW) begin
            q_push.cmd.kind = CMD_RAW;
        end else begin
            q_push.cmd.kind = CMD_MOD;
        end
    end

endmodule

FILE: src/xsr_fifo.sv
module xsr_fifo import xsr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_push_t   push,
    input  logic      pop,
    output q_status_t status,
    output cmd_t      head
);

    cmd_t                slot_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= QUEUE_AW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= QUEUE_AW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                count_reg <= (QUEUE_AW + 1)'(count_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                count_reg <= (QUEUE_AW + 1)'(count_reg - 1'b1);
            end
        end
    end

endmodule

FILE: src/xsr_back.sv
module xsr_back import xsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_status_t   q_status,
    input  cmd_t        q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // value[31:0]
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_SHIFT,
        ST_SEED_MUL0,
        ST_SEED_MUL1,
        ST_SEED_MUL2,
        ST_SEED_WRITE,
        ST_DRAW_READ,
        ST_DRAW_MIX,
        ST_DRAW_MUL,
        ST_DRAW_REDUCE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t              state_reg;
    cmd_kind_t           kind_reg;
    logic [31:0]         range_reg;
    logic [63:0]         seed_word_reg;
    logic [POOL_AW-1:0]  word_cnt_reg;
    logic [POOL_AW-1:0]  pool_index_reg;
    logic [POOL_DEPTH-1:0] valid_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         acc_reg;
    logic [31:0]         mix_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         dvd_reg;
    logic [DIV_CW-1:0]   bit_cnt_reg;
    logic [31:0]         res_reg;
    logic                m_tvalid_reg;
    logic [31:0]         m_tdata_reg;

    logic [63:0]         pool_mem [POOL_DEPTH];
    logic [63:0]         rd_a_reg;
    logic [63:0]         rd_b_reg;
    logic                rd_a_ok_reg;
    logic                rd_b_ok_reg;

    logic [POOL_AW-1:0]  idx_nxt;
    logic [63:0]         seed_word_next;
    logic [63:0]         seed_out;
    logic [63:0]         mix_next;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_out;
    logic [32:0]         trial;
    logic [32:0]         diff;
    logic [31:0]         rem_next;
    logic                mem_we;
    logic [POOL_AW-1:0]  mem_waddr;
    logic [63:0]         mem_wdata;

    assign idx_nxt  = POOL_AW'(pool_index_reg + 1'b1);
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Seed generator step: three dependent xor-shifts on the stored word.
    always_comb begin
        logic [63:0] w;
        w = seed_word_reg;
        w = w ^ (w >> SEED_SH1);
        w = w ^ (w << SEED_SH2);
        w = w ^ (w >> SEED_SH3);
        seed_word_next = w;
    end

    // The low 64 bits of the seed product are built from three 32x32 partial
    // products; the high-by-high term falls outside the word.
    assign seed_out = {32'(acc_reg[63:32] + prod_reg[31:0]), acc_reg[31:0]};

    // Entries never written since reset read as zero.
    always_comb begin
        logic [63:0] a;
        logic [63:0] b;
        a = rd_a_ok_reg ? rd_a_reg : 64'd0;
        b = rd_b_ok_reg ? rd_b_reg : 64'd0;
        b = b ^ (b << POOL_SH1);
        b = b ^ (b >> POOL_SH2);
        a = a ^ (a >> POOL_SH3);
        mix_next = a ^ b;
    end

    always_comb begin
        case (state_reg)
            ST_SEED_MUL0: begin
                mul_a = seed_word_reg[31:0];
                mul_b = SEED_MULT[31:0];
            end
            ST_SEED_MUL1: begin
                mul_a = seed_word_reg[31:0];
                mul_b = SEED_MULT[63:32];
            end
            ST_SEED_MUL2: begin
                mul_a = seed_word_reg[63:32];
                mul_b = SEED_MULT[31:0];
            end
            ST_DRAW_MUL: begin
                mul_a = mix_reg;
                mul_b = POOL_MULT[31:0];
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_out = 64'(mul_a) * 64'(mul_b);

    // One restoring division step per cycle.
    assign trial    = {rem_reg, dvd_reg[31]};
    assign diff     = trial - {1'b0, range_reg};
    assign rem_next = (trial >= {1'b0, range_reg}) ? diff[31:0] : trial[31:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = word_cnt_reg;
        mem_wdata = seed_out;
        case (state_reg)
            ST_SEED_WRITE: begin
                mem_we = 1'b1;
            end
            ST_DRAW_MIX: begin
                mem_we    = 1'b1;
                mem_waddr = idx_nxt;
                mem_wdata = mix_next;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pool_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= pool_mem[pool_index_reg];
        rd_b_reg <= pool_mem[idx_nxt];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_out;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seed_word_reg  <= SEED_INIT;
            pool_index_reg <= '0;
            valid_reg      <= '0;
            rd_a_ok_reg    <= 1'b0;
            rd_b_ok_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            rd_a_ok_reg <= valid_reg[pool_index_reg];
            rd_b_ok_reg <= valid_reg[idx_nxt];
            if (mem_we) begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        kind_reg  <= q_head.kind;
                        range_reg <= q_head.range;
                        case (q_head.kind)
                            CMD_RESEED: begin
                                word_cnt_reg <= '0;
                                state_reg    <= ST_SEED_SHIFT;
                            end
                            CMD_ONE: begin
                                res_reg   <= 32'd1;
                                state_reg <= ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DRAW_READ;
                            end
                        endcase
                    end
                end
                ST_SEED_SHIFT: begin
                    seed_word_reg <= seed_word_next;
                    state_reg     <= ST_SEED_MUL0;
                end
                ST_SEED_MUL0: begin
                    state_reg <= ST_SEED_MUL1;
                end
                ST_SEED_MUL1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_SEED_MUL2;
                end
                ST_SEED_MUL2: begin
                    acc_reg[63:32] <= 32'(acc_reg[63:32] + prod_reg[31:0]);
                    state_reg      <= ST_SEED_WRITE;
                end
                ST_SEED_WRITE: begin
                    word_cnt_reg <= POOL_AW'(word_cnt_reg + 1'b1);
                    if (word_cnt_reg == POOL_AW'(POOL_DEPTH - 1)) begin
                        res_reg   <= 32'd0;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_SEED_SHIFT;
                    end
                end
                ST_DRAW_READ: begin
                    state_reg <= ST_DRAW_MIX;
                end
                ST_DRAW_MIX: begin
                    mix_reg        <= mix_next[31:0];
                    pool_index_reg <= idx_nxt;
                    state_reg      <= ST_DRAW_MUL;
                end
                ST_DRAW_MUL: begin
                    state_reg <= ST_DRAW_REDUCE;
                end
                ST_DRAW_REDUCE: begin
                    if (kind_reg == CMD_RAW) begin
                        res_reg   <= prod_reg[31:0];
                        state_reg <= ST_DONE;
                    end else begin
                        dvd_reg     <= prod_reg[31:0];
                        rem_reg     <= 32'd0;
                        bit_cnt_reg <= DIV_CW'(DIV_STEPS - 1);
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg     <= rem_next;
                    dvd_reg     <= {dvd_reg[30:0], 1'b0};
                    bit_cnt_reg <= DIV_CW'(bit_cnt_reg - 1'b1);
                    if (bit_cnt_reg == '0) begin
                        res_reg   <= rem_next;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/xorshift1024_star_ranged_random_core.sv
// Random number source built on xorshift1024* with a ranged draw.
// Input channel (s_): s_tuser carries the mode (0 reseeds the pool, 1 draws),
// s_tdata carries the range. Result channel (m_): one transaction per input
// transaction, in order, m_tdata holding the value (0 for a reseed).
// Accepted transactions enter a two-entry queue; an execution engine takes
// them from it one at a time, so the input stays open while a draw is busy.
// Queue head to m_tvalid: range zero goes straight to the output, range all
// ones through the read, mix, multiply and reduce states, any other range
// also through the bit-per-cycle remainder unit, and a reseed through the
// shift, multiply and write states per pool word; one shared 32x32 multiplier
// builds each 64-bit seed product from three partial products. The engine
// pops the next item in the cycle after it loads the output register.
// Reset (aresetn low at a rising edge of aclk) empties the queue, clears the
// pool to zero through per-word valid bits, zeroes the pool index and loads
// the seed word; the block is ready in the next cycle.
// When the receiver stalls, the result waits in the output register, the
// engine finishes its next item and holds it, and the input keeps taking
// transactions until the queue is full.
module xorshift1024_star_ranged_random_core import xsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // range[31:0]
    input  logic        s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // value[31:0]
);

    q_push_t   q_push;
    q_status_t q_status;
    cmd_t      q_head;
    logic      q_pop;

    xsr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push)
    );

    xsr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .status  (q_status),
        .head    (q_head)
    );

    xsr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: src/xsr_checker.sv
`include "assert_macros.svh"

module xsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Transactions taken in whose results have not yet been taken out.
    logic [2:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
        end else if (in_acc && !out_acc) begin
            pend_reg <= 3'(pend_reg + 1'b1);
        end else if (out_acc && !in_acc) begin
            pend_reg <= 3'(pend_reg - 1'b1);
        end
    end

    `XSR_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")
    `XSR_ASSERT(a_out_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `XSR_ASSERT(a_no_extra_result, m_tvalid |-> pend_reg != 3'd0, "result without a pending transaction")
    `XSR_ASSERT(a_bounded_backlog, in_acc |-> pend_reg < 3'd4, "more transactions in flight than storage")

endmodule

bind xorshift1024_star_ranged_random_core xsr_checker u_xsr_checker (.*);

FILE: tb/xorshift1024_star_ranged_random_core_tb.sv
`timescale 1ns / 1ps

module xorshift1024_star_ranged_random_core_tb import xsr_pkg::*;;

    localparam int RANDOM_ITEMS  = 1550;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic        mode;
        logic [31:0] rng;
        logic        known;    // value below is the expected result
        logic [31:0] value;
    } stim_row_t;

    // Rows with a typed value: the pool is still zero, range zero, range one
    // and reseeds. All other rows are checked against the predictor.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_DRAW,   RANGE_ZERO,    1'b1, 32'd1},
        '{MODE_DRAW,   RANGE_RAW,     1'b1, 32'd0},
        '{MODE_DRAW,   32'h0000_0001, 1'b1, 32'd0},
        '{MODE_DRAW,   32'h0000_1234, 1'b1, 32'd0},
        '{MODE_DRAW,   RANGE_ZERO,    1'b1, 32'd1},
        '{MODE_RESEED, RANGE_RAW,     1'b1, 32'd0},
        '{MODE_DRAW,   RANGE_RAW,     1'b0, 32'd0},
        '{MODE_DRAW,   RANGE_RAW,     1'b0, 32'd0},
        '{MODE_DRAW,   32'h0000_0001, 1'b1, 32'd0},
        '{MODE_DRAW,   32'h0000_0002, 1'b0, 32'd0},
        '{MODE_DRAW,   RANGE_ZERO,    1'b1, 32'd1},
        '{MODE_DRAW,   32'h8000_0000, 1'b0, 32'd0},
        '{MODE_DRAW,   32'hFFFF_FFFE, 1'b0, 32'd0},
        '{MODE_DRAW,   32'h7FFF_FFFF, 1'b0, 32'd0},
        '{MODE_DRAW,   32'h0000_0003, 1'b0, 32'd0},
        '{MODE_DRAW,   32'h0000_FFFF, 1'b0, 32'd0},
        '{MODE_RESEED, RANGE_ZERO,    1'b1, 32'd0},
        '{MODE_DRAW,   RANGE_RAW,     1'b0, 32'd0},
        '{MODE_DRAW,   32'h0000_000A, 1'b0, 32'd0},
        '{MODE_DRAW,   RANGE_ZERO,    1'b1, 32'd1},
        '{MODE_RESEED, 32'h1234_5678, 1'b1, 32'd0},
        '{MODE_DRAW,   RANGE_RAW,     1'b0, 32'd0}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Predictor state.
    logic [63:0] gen_pool [POOL_DEPTH];
    logic [3:0]  gen_index;
    logic [63:0] gen_seed;

    logic [31:0] pending_values [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    xorshift1024_star_ranged_random_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void reset_generator();
        for (int i = 0; i < POOL_DEPTH; i++)
            gen_pool[i] = '0;
        gen_index = '0;
        gen_seed  = SEED_INIT;
    endfunction

    // Updates the generator state (not for range zero) and returns the value.
    function automatic logic [31:0] ranged_draw(input logic mode, input logic [31:0] rng);
        logic [63:0] w;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] prod;
        logic [3:0]  nxt;
        logic [31:0] raw;
        if (mode == MODE_RESEED) begin
            for (int i = 0; i < POOL_DEPTH; i++) begin
                w = gen_seed;
                w ^= w >> SEED_SH1;
                w ^= w << SEED_SH2;
                w ^= w >> SEED_SH3;
                gen_seed    = w;
                gen_pool[i] = w * SEED_MULT;
            end
            return 32'd0;
        end
        if (rng == RANGE_ZERO)
            return 32'd1;
        nxt = gen_index + 4'd1;
        a = gen_pool[gen_index];
        b = gen_pool[nxt];
        b ^= b << POOL_SH1;
        b ^= b >> POOL_SH2;
        a ^= a >> POOL_SH3;
        gen_pool[nxt] = a ^ b;
        gen_index     = nxt;
        prod = gen_pool[nxt] * POOL_MULT;
        raw  = prod[31:0];
        if (rng != RANGE_RAW)
            raw = raw % rng;
        return raw;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_range();
        case ($urandom_range(0, 9))
            0: return RANGE_ZERO;
            1: return RANGE_RAW;
            2: return 32'd1;
            3: return $urandom_range(2, 16);
            4: return 32'd1 << $urandom_range(0, 31);
            5: return RANGE_RAW - $urandom_range(1, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [31:0] rng,
                             input logic known, input logic [31:0] value);
        int          gap;
        logic [31:0] predicted;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(0, 1));
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= rng;
        do @(posedge aclk); while (!s_tready);
        predicted = ranged_draw(mode, rng);
        pending_values.push_back(known ? value : predicted);
    endtask

    // Holds the input idle until every outstanding result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge aclk);
    endtask

    // Result receiver with random back-pressure.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = pick_gap();
                repeat (n) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result transaction: value %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_tdata !== want) begin
                    $error("value mismatch: expected %h, actual %h", want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[xorshift1024_star_ranged_random_core] ERROR");
            $finish;
        end
    end

    initial begin
        logic mode;
        reset_generator();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].mode, DIRECTED[i].rng, DIRECTED[i].known, DIRECTED[i].value);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // One stretch in three runs without idling on either side.
            if (i % 150 == 0)
                calm = (i / 150) % 3 == 1;
            if (i == 700)
                drain_results();
            mode = ($urandom_range(0, 39) == 0) ? MODE_RESEED : MODE_DRAW;
            send_item(mode, pick_range(), 1'b0, 32'd0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[xorshift1024_star_ranged_random_core] OK");
        else
            $display("[xorshift1024_star_ranged_random_core] ERROR");
        $finish;
    end

endmodule
